// ----- hw/rtl/a8n1_pkg.sv -----
// Package for the 8N1 bit-stream deframer: beat structs, status and op codes.
// No dependencies; imported by every deframer module.
package a8n1_pkg;

    localparam int unsigned SHIFT_W    = 17;
    localparam int unsigned GROUP_BITS = 10;
    localparam int unsigned MIN_LEN    = 8;
    localparam int unsigned LEN_EXTRA  = 3;
    localparam logic [3:0]  INITIAL_SKIP_RST = 4'd8;

    typedef enum logic [1:0] {
        ST_NEED     = 2'd0,
        ST_FRAMING  = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_DONE     = 2'd3
    } status_t;

    typedef enum logic {
        OP_FEED    = 1'b0,
        OP_RESTART = 1'b1
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] wire_byte;
    } in_beat_t;

    typedef struct packed {
        status_t    status;
        logic       byte_valid;
        logic [7:0] data_byte;
        logic [5:0] byte_index;
    } out_beat_t;

endpackage

// ----- hw/rtl/a8n1_core.sv -----
// Deframer state and single-pass decode logic for one stream beat.
// Depends on a8n1_pkg.
module a8n1_core
    import a8n1_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic [3:0] initial_skip,
    input  logic      fire,
    input  in_beat_t  in_beat,
    output out_beat_t result
);

    localparam logic [5:0] MaxFrameW = 6'(MAX_FRAME);

    logic [SHIFT_W-1:0] bit_shift_reg, bit_shift_next;
    logic [4:0]         bits_held_reg, bits_held_next;
    logic [3:0]         skip_left_reg, skip_left_next;
    logic [5:0]         frame_total_reg, frame_total_next;
    logic [5:0]         write_pos_reg, write_pos_next;
    logic               halted_reg, halted_next;
    status_t            held_status_reg, held_status_next;

    logic [3:0]         keep;
    logic [7:0]         mask;
    logic [24:0]        shifted;
    logic [SHIFT_W-1:0] merged;
    logic [4:0]         held;
    logic [2:0]         offset;
    logic [9:0]         group;
    logic [7:0]         decoded;
    logic [4:0]         len;
    logic [5:0]         ft_new;
    logic [5:0]         wp_inc;

    assign keep    = 4'd8 - {1'b0, skip_left_reg[2:0]};
    assign mask    = 8'((9'd1 << keep) - 9'd1);
    assign shifted = {8'd0, bit_shift_reg} << keep;
    assign merged  = shifted[SHIFT_W-1:0] | {9'd0, in_beat.wire_byte & mask};
    assign held    = bits_held_reg + {1'b0, keep};
    assign offset  = 3'(held - 5'(GROUP_BITS));
    assign group   = 10'(merged >> offset);
    assign decoded = {group[1], group[2], group[3], group[4],
                      group[5], group[6], group[7], group[8]};
    assign len     = decoded[4:0];
    assign ft_new  = {1'b0, len} + 6'(LEN_EXTRA);
    assign wp_inc  = write_pos_reg + 6'd1;

    always_comb begin
        bit_shift_next   = bit_shift_reg;
        bits_held_next   = bits_held_reg;
        skip_left_next   = skip_left_reg;
        frame_total_next = frame_total_reg;
        write_pos_next   = write_pos_reg;
        halted_next      = halted_reg;
        held_status_next = held_status_reg;
        result           = '{status: ST_NEED, byte_valid: 1'b0,
                             data_byte: 8'd0, byte_index: 6'd0};
        if (fire) begin
            if (in_beat.op == OP_RESTART) begin
                bit_shift_next   = '0;
                bits_held_next   = '0;
                skip_left_next   = initial_skip;
                frame_total_next = '0;
                write_pos_next   = '0;
                halted_next      = 1'b0;
                held_status_next = ST_NEED;
            end else if (halted_reg) begin
                result.status = held_status_reg;
            end else if (skip_left_reg[3]) begin
                skip_left_next = skip_left_reg - 4'd8;
            end else begin
                bit_shift_next = merged;
                bits_held_next = held;
                skip_left_next = '0;
                if (held >= 5'(GROUP_BITS)) begin
                    bits_held_next = held - 5'(GROUP_BITS);
                    if (group[9] || !group[0]) begin
                        result.status = ST_FRAMING;
                    end else if (write_pos_reg >= MaxFrameW) begin
                        result.status = ST_OVERFLOW;
                    end else begin
                        result.byte_valid = 1'b1;
                        result.data_byte  = decoded;
                        result.byte_index = write_pos_reg;
                        write_pos_next    = wp_inc;
                        if (write_pos_reg == 6'd0) begin
                            if (len < 5'(MIN_LEN)) begin
                                result.status = ST_FRAMING;
                            end else begin
                                frame_total_next = ft_new;
                                if (ft_new > MaxFrameW) begin
                                    result.status = ST_OVERFLOW;
                                end else if (wp_inc >= ft_new) begin
                                    result.status = ST_DONE;
                                end
                            end
                        end else if (frame_total_reg != 6'd0 && wp_inc >= frame_total_reg) begin
                            result.status = ST_DONE;
                        end
                    end
                end
                if (result.status != ST_NEED) begin
                    halted_next      = 1'b1;
                    held_status_next = result.status;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_shift_reg   <= '0;
            bits_held_reg   <= '0;
            skip_left_reg   <= INITIAL_SKIP_RST;
            frame_total_reg <= '0;
            write_pos_reg   <= '0;
            halted_reg      <= 1'b0;
            held_status_reg <= ST_NEED;
        end else begin
            bit_shift_reg   <= bit_shift_next;
            bits_held_reg   <= bits_held_next;
            skip_left_reg   <= skip_left_next;
            frame_total_reg <= frame_total_next;
            write_pos_reg   <= write_pos_next;
            halted_reg      <= halted_next;
            held_status_reg <= held_status_next;
        end
    end

    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_held_reg < 5'(GROUP_BITS))
        else $error("bits_held exceeds one group");

    a_halt_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_beat.op == OP_FEED && halted_reg |=>
            $stable(write_pos_reg) && $stable(bits_held_reg) && halted_reg)
        else $error("state moved while halted");

    a_byte_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        result.byte_valid |-> fire && !halted_reg && result.byte_index == write_pos_reg)
        else $error("byte reported outside a live feed beat");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_beat.op == OP_RESTART |=>
            write_pos_reg == 6'd0 && bits_held_reg == 5'd0 && !halted_reg)
        else $error("restart did not clear state");

endmodule

// ----- hw/rtl/async_8n1_bitstream_deframer_unit.sv -----
// Top level of the 8N1 bit-stream deframer: input register, decode core, result register.
// Depends on a8n1_pkg and a8n1_core.
//
//   port group   dir   handshake         payload
//   s_*          in    s_valid/s_ready   in_beat_t  (op, wire_byte)
//   m_*          out   m_valid/m_ready   out_beat_t (status, byte_valid, data_byte, byte_index)
//   cfg_*        in    cfg_wr_en         initial_skip (4 bits)
//
// One beat per cycle while the result side does not stall; an accepted beat goes into the
// input register, then through the core into the result register, which drives m_valid.
// The decode of one beat is a single pass through the core between the two registers.
// Reset clears the pipeline, sets initial_skip to 8 and restarts the deframer state.
// A stalled result holds in the result register; the input register takes the next
// beat whenever the result register frees up in the same cycle.
module async_8n1_bitstream_deframer_unit
    import a8n1_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic [3:0] cfg_wr_data,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic      in_valid_reg, in_valid_next;
    in_beat_t  in_beat_reg;
    logic      out_valid_reg, out_valid_next;
    out_beat_t out_beat_reg;
    logic [3:0] initial_skip_reg;
    logic      advance;
    out_beat_t core_result;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_beat_reg;

    a8n1_core #(
        .MAX_FRAME(MAX_FRAME)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .initial_skip(initial_skip_reg),
        .fire        (advance),
        .in_beat     (in_beat_reg),
        .result      (core_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            initial_skip_reg <= INITIAL_SKIP_RST;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                initial_skip_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_beat_reg <= s_data;
        end
        if (advance) begin
            out_beat_reg <= core_result;
        end
    end

endmodule

// ----- verif/tb_async_8n1_bitstream_deframer_unit.sv -----
// Testbench for the 8N1 bit-stream deframer: builds framed bit streams, predicts each
// result beat with a behavioral deframer and checks the result channel in order.
// Depends on a8n1_pkg and async_8n1_bitstream_deframer_unit.
module tb_async_8n1_bitstream_deframer_unit
    import a8n1_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_FRAME      = 32;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES    = 150;
    localparam int unsigned PHASE_ITEMS    = 72;
    localparam logic [3:0]  SKIP_PLAN [4]  = '{4'd0, 4'd15, 4'd1, 4'd7};

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [3:0] cfg_wr_data = 4'd0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    in_beat_t   s_data      = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    out_beat_t  m_data;

    // deframer state mirrored by the predictor
    logic [3:0]  skip_cfg;
    logic [16:0] shift_reg;
    logic [4:0]  held_bits;
    logic [3:0]  skip_cnt;
    logic [5:0]  frame_len;
    logic [5:0]  wr_pos;
    logic        halted_m;
    status_t     halt_status;

    in_beat_t    stream_q [$];
    out_beat_t   deframe_results_q [$];
    logic [7:0]  body_q [$];

    bit          no_idle      = 1'b0;
    int unsigned queued_items = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned rx_count     = 0;
    int unsigned hold_left    = 0;
    int unsigned holds_done   = 0;
    int unsigned quiet_cycles = 0;

    async_8n1_bitstream_deframer_unit #(
        .MAX_FRAME(MAX_FRAME)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    initial forever #5 aclk = ~aclk;

    function automatic void restart_deframer();
        shift_reg   = '0;
        held_bits   = '0;
        skip_cnt    = skip_cfg;
        frame_len   = '0;
        wr_pos      = '0;
        halted_m    = 1'b0;
        halt_status = ST_NEED;
    endfunction

    function automatic out_beat_t deframe_beat(input in_beat_t beat);
        out_beat_t   res;
        logic [31:0] acc;
        logic [9:0]  grp;
        logic [7:0]  dbyte;
        int unsigned keep;
        res = '0;
        res.status = ST_NEED;
        if (beat.op == OP_RESTART) begin
            restart_deframer();
        end else if (halted_m) begin
            res.status = halt_status;
        end else if (skip_cnt >= 4'd8) begin
            skip_cnt = skip_cnt - 4'd8;
        end else begin
            keep = 8 - skip_cnt;
            acc = ({15'd0, shift_reg} << keep) | (32'(beat.wire_byte) & ((32'd1 << keep) - 1));
            shift_reg = acc[16:0];
            held_bits = held_bits + 5'(keep);
            skip_cnt = '0;
            if (held_bits >= 5'd10) begin
                acc = {15'd0, shift_reg} >> (held_bits - 5'd10);
                grp = acc[9:0];
                held_bits = held_bits - 5'd10;
                if (grp[9] || !grp[0]) begin
                    res.status = ST_FRAMING;
                end else begin
                    for (int i = 0; i < 8; i++) dbyte[i] = grp[8 - i];
                    if (wr_pos >= MAX_FRAME) begin
                        res.status = ST_OVERFLOW;
                    end else begin
                        res.byte_valid = 1'b1;
                        res.data_byte  = dbyte;
                        res.byte_index = wr_pos;
                        wr_pos = wr_pos + 6'd1;
                        if (wr_pos == 6'd1) begin
                            if (dbyte[4:0] < MIN_LEN) begin
                                res.status = ST_FRAMING;
                            end else begin
                                frame_len = 6'(dbyte[4:0]) + 6'(LEN_EXTRA);
                                if (frame_len > MAX_FRAME) res.status = ST_OVERFLOW;
                            end
                        end
                        if (res.status == ST_NEED && frame_len != 0 && wr_pos >= frame_len) begin
                            res.status = ST_DONE;
                        end
                    end
                end
            end
            if (res.status != ST_NEED) begin
                halted_m    = 1'b1;
                halt_status = res.status;
            end
        end
        return res;
    endfunction

    task automatic push_beat(input op_t op, input logic [7:0] wb);
        in_beat_t beat;
        beat.op = op;
        beat.wire_byte = wb;
        stream_q.push_back(beat);
        queued_items++;
    endtask

    task automatic make_body(input int unsigned len, input int unsigned count);
        body_q.delete();
        body_q.push_back({3'($urandom_range(0, 7)), 5'(len)});
        for (int i = 1; i < count; i++) body_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // lead bits, then start 0, data LSB first, stop 1 per body byte, earliest bit in MSB
    task automatic queue_frame(input int unsigned lead_bits, input int flip_at,
                               input int unsigned extra);
        bit          bits_q [$];
        logic [7:0]  wb;
        int unsigned pos;
        for (int i = 0; i < lead_bits; i++) bits_q.push_back(1'($urandom_range(0, 1)));
        foreach (body_q[j]) begin
            bits_q.push_back(1'b0);
            for (int b = 0; b < 8; b++) bits_q.push_back(body_q[j][b]);
            bits_q.push_back(1'b1);
        end
        if (flip_at >= 0) bits_q[lead_bits + flip_at] = !bits_q[lead_bits + flip_at];
        pos = 0;
        while (pos < bits_q.size()) begin
            for (int k = 0; k < 8; k++) begin
                wb[7 - k] = (pos + k < bits_q.size()) ? bits_q[pos + k]
                                                      : 1'($urandom_range(0, 1));
            end
            push_beat(OP_FEED, wb);
            pos += 8;
        end
        repeat (extra) push_beat(OP_FEED, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain();
        while (stream_q.size() != 0 || deframe_results_q.size() != 0) @(negedge aclk);
    endtask

    always @(posedge aclk) begin : driver
        logic took;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            took = s_valid && s_ready;
            if (took) begin
                deframe_results_q.push_back(deframe_beat(s_data));
                void'(stream_q.pop_front());
            end
            if (!s_valid || took) begin
                if (stream_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 21)) begin
                    s_valid <= 1'b1;
                    s_data  <= stream_q[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : monitor
        out_beat_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                rx_count++;
                if (deframe_results_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("unexpected beat %0d: status=%0d valid=%0d data=%02h index=%0d",
                                 rx_count, m_data.status, m_data.byte_valid, m_data.data_byte,
                                 m_data.byte_index);
                    end
                end else begin
                    want = deframe_results_q.pop_front();
                    if (m_data.status !== want.status || m_data.byte_valid !== want.byte_valid ||
                        m_data.data_byte !== want.data_byte ||
                        m_data.byte_index !== want.byte_index) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("beat %0d expected status=%0d valid=%0d data=%02h index=%0d",
                                     rx_count, want.status, want.byte_valid, want.data_byte,
                                     want.byte_index);
                            $display("beat %0d actual   status=%0d valid=%0d data=%02h index=%0d",
                                     rx_count, m_data.status, m_data.byte_valid, m_data.data_byte,
                                     m_data.byte_index);
                        end
                    end
                end
            end
            // hold off the result side while the input side keeps offering beats
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (holds_done < 2 && stream_q.size() > 30 &&
                         rx_count >= 60 * (holds_done + 1)) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
                m_ready <= 1'b0;
            end else begin
                m_ready <= no_idle || ($urandom_range(0, 99) >= 21);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        logic [3:0]  skip_val;
        int unsigned gen_skip;
        int unsigned target;
        int unsigned pick;
        int unsigned len;
        skip_cfg = INITIAL_SKIP_RST;
        restart_deframer();
        gen_skip = INITIAL_SKIP_RST;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        body_q = '{8'hE8, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE, 8'h0F, 8'hF0};
        queue_frame(gen_skip, -1, 1);
        push_beat(OP_RESTART, 8'hFF);
        body_q = '{8'h03};
        queue_frame(gen_skip, -1, 0);
        push_beat(OP_RESTART, 8'h00);
        body_q = '{8'h1F, 8'h00};
        queue_frame(gen_skip, -1, 0);
        push_beat(OP_RESTART, 8'($urandom_range(0, 255)));
        body_q = '{8'h08, 8'h00};
        queue_frame(gen_skip, 9, 0);

        target = queued_items;
        for (int phase = 0; phase < 7; phase++) begin
            drain();
            repeat (4) @(posedge aclk);
            skip_val = (phase < 4) ? SKIP_PLAN[phase] : 4'($urandom_range(0, 15));
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= skip_val;
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            skip_cfg = skip_val;
            gen_skip = skip_val;
            @(negedge aclk);
            no_idle = (phase == 3);
            target += PHASE_ITEMS;
            while (queued_items < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 62) begin
                    push_beat(OP_RESTART, 8'($urandom_range(0, 255)));
                    len = ($urandom_range(0, 3) != 0) ? $urandom_range(8, 12)
                                                      : $urandom_range(13, 29);
                    make_body(len, len + 3);
                    queue_frame(gen_skip, -1, $urandom_range(0, 2));
                end else if (pick < 74) begin
                    push_beat(OP_RESTART, 8'($urandom_range(0, 255)));
                    len = $urandom_range(8, 12);
                    make_body(len, len + 3);
                    queue_frame(gen_skip, $urandom_range(0, (len + 3) * 10 - 1), 1);
                end else if (pick < 82) begin
                    push_beat(OP_RESTART, 8'($urandom_range(0, 255)));
                    make_body($urandom_range(0, 7), $urandom_range(1, 3));
                    queue_frame(gen_skip, -1, 0);
                end else if (pick < 89) begin
                    push_beat(OP_RESTART, 8'($urandom_range(0, 255)));
                    make_body($urandom_range(30, 31), 2);
                    queue_frame(gen_skip, -1, 0);
                end else if (pick < 95) begin
                    push_beat(OP_RESTART, 8'($urandom_range(0, 255)));
                    repeat ($urandom_range(1, 6)) push_beat(OP_FEED, 8'($urandom_range(0, 255)));
                end else begin
                    repeat ($urandom_range(1, 3)) push_beat(OP_FEED, 8'($urandom_range(0, 255)));
                end
            end
        end

        drain();
        no_idle = 1'b0;
        repeat (8) @(posedge aclk);
        if (mismatch_cnt == 0 && deframe_results_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
